// ----- src/ptt_pkg.sv -----
`timescale 1ns / 1ps

package ptt_pkg;

  // Command codes carried by an input item.
  typedef enum logic [1:0] {
    CMD_TICK      = 2'd0,
    CMD_DIV_WRITE = 2'd1,
    CMD_CNT_WRITE = 2'd2,
    CMD_NONE      = 2'd3
  } cmd_t;

  // Register indexes on the configuration port (byte address = 4 * index).
  localparam logic [1:0] REG_ENABLE = 2'd0;
  localparam logic [1:0] REG_RATE   = 2'd1;
  localparam logic [1:0] REG_RELOAD = 2'd2;

  localparam int          ACC_W   = 32;
  localparam logic [7:0]  CNT_MAX = 8'hFF;

  // Every period is a power of two, so the remainder is a mask and
  // reaching the period means some bit above the mask is set.
  function automatic logic [ACC_W-1:0] period_mask(input logic [1:0] rate);
    logic [ACC_W-1:0] mask;
    case (rate)
      2'd0:    mask = ACC_W'(1023);
      2'd1:    mask = ACC_W'(15);
      2'd2:    mask = ACC_W'(63);
      2'd3:    mask = ACC_W'(255);
      default: mask = ACC_W'(1023);
    endcase
    return mask;
  endfunction

endpackage

// ----- src/prescaled_tick_timer_with_reload.sv -----
`timescale 1ns / 1ps

// A result becomes valid once its item has left the input register: the item waits there, then
// the timer state and the result register update together; an output stall holds it in between.
// Throughput: one item per cycle while the output is not stalled; the single-pass update of the counters sets this.
// Reset (rst_n low, synchronous): all timer state, the configuration registers and valid flags clear.
// Configuration writes take effect at the APB access edge; reads return the registers.
module prescaled_tick_timer_with_reload
  import ptt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_cycles,
  input  logic [7:0]  in_write_value,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_divider,
  output logic [7:0]  out_counter,
  output logic        out_timer_irq,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration registers.
  logic       enable_r;
  logic [1:0] rate_r;
  logic [7:0] reload_r;

  // Input register.
  logic       s1_valid_r;
  cmd_t       s1_cmd_r;
  logic [7:0] s1_cycles_r;
  logic [7:0] s1_wval_r;

  // Timer state; the result fields come straight from it.
  logic [7:0]       fine_r, fine_nxt;
  logic [ACC_W-1:0] prescale_r, prescale_nxt;
  logic [7:0]       divider_r, divider_nxt;
  logic [7:0]       counter_r, counter_nxt;
  logic             irq_r, irq_nxt;
  logic             out_valid_r;

  logic             advance;
  logic             cfg_write;
  logic [8:0]       fine_sum;
  logic [ACC_W-1:0] pre_sum;
  logic [ACC_W-1:0] mask;
  logic             reached;

  // The item in the input register moves on when the result register is free.
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  assign out_valid     = out_valid_r;
  assign out_divider   = divider_r;
  assign out_counter   = counter_r;
  assign out_timer_irq = irq_r;

  // APB configuration port.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      rate_r   <= 2'd0;
      reload_r <= 8'd0;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_ENABLE: enable_r <= pwdata[0];
        REG_RATE:   rate_r   <= pwdata[1:0];
        REG_RELOAD: reload_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ENABLE: prdata = {31'd0, enable_r};
      REG_RATE:   prdata = {30'd0, rate_r};
      REG_RELOAD: prdata = {24'd0, reload_r};
      default:    prdata = 32'd0;
    endcase
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_cmd_r    <= cmd_t'(in_command);
      s1_cycles_r <= in_cycles;
      s1_wval_r   <= in_write_value;
    end
  end

  // Next timer state for the item in the input register.
  always_comb begin
    fine_sum     = {1'b0, fine_r} + {1'b0, s1_cycles_r};
    pre_sum      = prescale_r + {{(ACC_W-8){1'b0}}, s1_cycles_r};
    mask         = period_mask(rate_r);
    reached      = |(pre_sum & ~mask);
    fine_nxt     = fine_r;
    prescale_nxt = prescale_r;
    divider_nxt  = divider_r;
    counter_nxt  = counter_r;
    irq_nxt      = 1'b0;
    case (s1_cmd_r)
      CMD_TICK: begin
        // The fine sum never reaches 512, so bit 8 alone marks a divider step.
        fine_nxt     = fine_sum[7:0];
        prescale_nxt = pre_sum;
        if (fine_sum[8]) begin
          divider_nxt = divider_r + 8'd1;
        end
        if (enable_r && reached) begin
          if (counter_r == CNT_MAX) begin
            counter_nxt = reload_r;
            irq_nxt     = 1'b1;
          end else begin
            counter_nxt = counter_r + 8'd1;
          end
          prescale_nxt = pre_sum & mask;
        end
      end
      CMD_DIV_WRITE: divider_nxt = 8'd0;
      CMD_CNT_WRITE: counter_nxt = s1_wval_r;
      default: ;
    endcase
  end

  // State and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fine_r      <= 8'd0;
      prescale_r  <= '0;
      divider_r   <= 8'd0;
      counter_r   <= 8'd0;
      irq_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        fine_r     <= fine_nxt;
        prescale_r <= prescale_nxt;
        divider_r  <= divider_nxt;
        counter_r  <= counter_nxt;
        irq_r      <= irq_nxt;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // A held item in the input register is never dropped.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r)
    else $error("input register lost an item while stalled");

  // Only a tick can raise the interrupt.
  a_irq_tick: assert property (@(posedge clk) disable iff (!rst_n)
    advance && s1_cmd_r != CMD_TICK |=> !irq_r)
    else $error("interrupt raised by a non-tick item");

  // A counter write loads the counter with the written value.
  a_cnt_write: assert property (@(posedge clk) disable iff (!rst_n)
    advance && s1_cmd_r == CMD_CNT_WRITE |=> counter_r == $past(s1_wval_r))
    else $error("counter write not applied");

  // After an enabled tick the prescale accumulator is below the period.
  a_pre_range: assert property (@(posedge clk) disable iff (!rst_n)
    advance && s1_cmd_r == CMD_TICK && enable_r
    |=> (prescale_r & ~period_mask($past(rate_r))) == '0)
    else $error("prescale accumulator not reduced");

endmodule

// ----- bench/prescaled_tick_timer_with_reload_tb.sv -----
`timescale 1ns / 1ps

module prescaled_tick_timer_with_reload_tb;
  import ptt_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 216;

  typedef struct packed {
    cmd_t       command;
    logic [7:0] cycles;
    logic [7:0] write_value;
  } timer_item_t;

  typedef struct packed {
    logic [7:0] divider;
    logic [7:0] counter;
    logic       irq;
  } readout_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_command = CMD_TICK;
  logic [7:0]  in_cycles = 8'd0;
  logic [7:0]  in_write_value = 8'd0;

  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_divider;
  logic [7:0]  out_counter;
  logic        out_timer_irq;

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = 4'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  // Own copy of the timer state and its registers.
  logic [8:0]  m_fine;
  logic [31:0] m_prescale;
  logic [7:0]  m_divider;
  logic [7:0]  m_counter;
  logic        m_enable;
  logic [1:0]  m_rate;
  logic [7:0]  m_reload;

  timer_item_t tick_items[$];
  readout_t    pending_readouts[$];
  timer_item_t cur_item;

  int  in_gap;
  int  out_stall;
  bit  steady;
  int  cycle_count;
  int  mismatches;
  int  readouts_seen;
  int  items_accepted;
  int  ticks_accepted;
  int  overflows_predicted;
  int  settings_used;

  prescaled_tick_timer_with_reload i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_cycles      (in_cycles),
    .in_write_value (in_write_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_divider    (out_divider),
    .out_counter    (out_counter),
    .out_timer_irq  (out_timer_irq),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // Free-running clock, 20 ns period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Applies one item to the timer state and returns the readout it should produce.
  function automatic readout_t advance_timer(input timer_item_t item);
    readout_t    r;
    logic [31:0] period;
    r.irq = 1'b0;
    case (item.command)
      CMD_TICK: begin
        m_fine = m_fine + 9'(item.cycles);
        m_prescale = m_prescale + 32'(item.cycles);
        // The divider steps at most once, whatever the fine backlog.
        if (m_fine >= 9'd256) begin
          m_divider = m_divider + 8'd1;
          m_fine = m_fine - 9'd256;
        end
        if (m_enable) begin
          case (m_rate)
            2'd0:    period = 32'd1024;
            2'd1:    period = 32'd16;
            2'd2:    period = 32'd64;
            default: period = 32'd256;
          endcase
          // One counter step per tick; the remainder of the period is kept.
          if (m_prescale >= period) begin
            if (m_counter == CNT_MAX) begin
              m_counter = m_reload;
              r.irq = 1'b1;
              overflows_predicted++;
            end else begin
              m_counter = m_counter + 8'd1;
            end
            m_prescale = m_prescale % period;
          end
        end
        ticks_accepted++;
      end
      CMD_DIV_WRITE: m_divider = 8'd0;
      CMD_CNT_WRITE: m_counter = item.write_value;
      default: ;
    endcase
    r.divider = m_divider;
    r.counter = m_counter;
    return r;
  endfunction

  // One APB write: setup cycle, then the access cycle that commits it.
  task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (index)
      REG_ENABLE: m_enable = value[0];
      REG_RATE:   m_rate = value[1:0];
      REG_RELOAD: m_reload = value[7:0];
      default: ;
    endcase
  endtask

  task automatic set_timer(input logic enable, input logic [1:0] rate, input logic [7:0] reload);
    write_reg(REG_ENABLE, {31'd0, enable});
    write_reg(REG_RATE, {30'd0, rate});
    write_reg(REG_RELOAD, {24'd0, reload});
    settings_used++;
  endtask

  task automatic queue_item(input cmd_t command, input logic [7:0] cycles,
                            input logic [7:0] write_value);
    timer_item_t item;
    item.command = command;
    item.cycles = cycles;
    item.write_value = write_value;
    tick_items.push_back(item);
  endtask

  // Waits until every queued item has gone in and every readout has come back.
  task automatic drain;
    do @(negedge clk);
    while (tick_items.size() != 0 || in_valid || pending_readouts.size() != 0);
  endtask

  // Driver: presents queued items, with random idle bursts between them unless the phase is steady.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        pending_readouts.push_back(advance_timer(cur_item));
        items_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (!steady && $urandom_range(0, 15) == 0) begin
          in_gap = $urandom_range(0, 17);
          in_valid <= 1'b0;
        end else if (tick_items.size() > 0) begin
          cur_item = tick_items.pop_front();
          in_valid       <= 1'b1;
          in_command     <= cur_item.command;
          in_cycles      <= cur_item.cycles;
          in_write_value <= cur_item.write_value;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each readout against the oldest prediction and stalls at random unless steady.
  always @(posedge clk) begin
    readout_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        readouts_seen++;
        if (pending_readouts.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("readout %0d arrived with nothing predicted: div %02h cnt %02h irq %0b",
                     readouts_seen, out_divider, out_counter, out_timer_irq);
        end else begin
          want = pending_readouts.pop_front();
          if (out_divider !== want.divider || out_counter !== want.counter ||
              out_timer_irq !== want.irq) begin
            mismatches++;
            if (mismatches <= 10)
              $display("readout %0d: expected div %02h cnt %02h irq %0b, got div %02h cnt %02h irq %0b",
                       readouts_seen, want.divider, want.counter, want.irq,
                       out_divider, out_counter, out_timer_irq);
          end
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else if (!steady && $urandom_range(0, 15) == 0) begin
        out_stall = $urandom_range(0, 17);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("run timed out after %0d cycles with %0d readouts outstanding",
               cycle_count, pending_readouts.size());
      $display("prescaled_tick_timer_with_reload_tb NOT OK");
      $finish;
    end
  end

  initial begin
    cmd_t       command;
    logic [7:0] cycles;
    logic [7:0] write_value;
    logic [7:0] reload;
    int         pick;
    m_fine = '0;
    m_prescale = '0;
    m_divider = '0;
    m_counter = '0;
    m_enable = 1'b0;
    m_rate = 2'd0;
    m_reload = 8'd0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Fast period: divider and counter steps, a forced overflow, writes and the unused command.
    set_timer(1'b1, 2'd1, 8'hAA);
    queue_item(CMD_TICK, 8'd0, 8'd0);
    queue_item(CMD_TICK, 8'd255, 8'd0);
    queue_item(CMD_TICK, 8'd1, 8'd0);
    queue_item(CMD_CNT_WRITE, 8'd0, 8'hFF);
    queue_item(CMD_TICK, 8'd16, 8'h00);
    queue_item(CMD_DIV_WRITE, 8'hFF, 8'hFF);
    queue_item(CMD_NONE, 8'hFF, 8'hFF);
    queue_item(CMD_NONE, 8'h00, 8'h00);
    queue_item(CMD_CNT_WRITE, 8'hFF, 8'h00);
    queue_item(CMD_CNT_WRITE, 8'h00, 8'hFF);
    queue_item(CMD_TICK, 8'd255, 8'h55);
    queue_item(CMD_TICK, 8'd128, 8'hAA);
    queue_item(CMD_TICK, 8'd128, 8'h00);
    drain();

    // Timer off: the prescale count piles up just past the longest period.
    set_timer(1'b0, 2'd0, 8'h00);
    repeat (4) queue_item(CMD_TICK, 8'd255, 8'd0);
    queue_item(CMD_CNT_WRITE, 8'd0, 8'hFF);
    drain();

    // Timer back on at the slow period: one step only, remainder kept.
    set_timer(1'b1, 2'd0, 8'h00);
    queue_item(CMD_TICK, 8'd255, 8'd0);
    queue_item(CMD_TICK, 8'd0, 8'd0);
    queue_item(CMD_TICK, 8'd255, 8'd0);
    drain();

    // Random phases over all periods, both enables and the reload extremes.
    for (int p = 0; p < 8; p++) begin
      if (p == 0)
        reload = 8'h00;
      else if (p == 1)
        reload = 8'hFF;
      else
        reload = 8'($urandom_range(0, 255));
      set_timer(p % 3 != 2, 2'(p), reload);
      steady = (p == 7);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 80)
          command = CMD_TICK;
        else if (pick < 87)
          command = CMD_CNT_WRITE;
        else if (pick < 93)
          command = CMD_DIV_WRITE;
        else
          command = CMD_NONE;
        case ($urandom_range(0, 7))
          0:       cycles = 8'd0;
          1:       cycles = 8'd255;
          2:       cycles = 8'($urandom_range(1, 20));
          default: cycles = 8'($urandom_range(0, 255));
        endcase
        // Counter writes lean toward the top so that overflows come often.
        if ($urandom_range(0, 3) == 0)
          write_value = 8'($urandom_range(0, 255));
        else
          write_value = 8'($urandom_range(8'hF8, 8'hFF));
        queue_item(command, cycles, write_value);
      end
      drain();
    end

    repeat (4) @(posedge clk);
    $display("Checked %0d readouts from %0d items (%0d ticks) over %0d timer settings.",
             readouts_seen, items_accepted, ticks_accepted, settings_used);
    $display("Counter overflowed with reload %0d times; %0d mismatches.",
             overflows_predicted, mismatches);
    if (mismatches == 0 && pending_readouts.size() == 0)
      $display("prescaled_tick_timer_with_reload_tb OK");
    else
      $display("prescaled_tick_timer_with_reload_tb NOT OK");
    $finish;
  end

endmodule
